// ===== design/cdim_pkg.sv =====
// ----------------------------------------------------------------------------
// cdim_pkg
// Types and codes shared by the cumulative distance index map.
// ----------------------------------------------------------------------------
`default_nettype none

package cdim_pkg;

  localparam int DIST_W = 40;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // func codes
  localparam logic [2:0] FN_BEGIN = 3'd0;
  localparam logic [2:0] FN_ADD   = 3'd1;
  localparam logic [2:0] FN_END   = 3'd2;
  localparam logic [2:0] FN_LKD   = 3'd3;
  localparam logic [2:0] FN_LKID  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BEYOND   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [63:0] string_id;
    logic signed [63:0] item_id;
    logic signed [27:0] point_x;
    logic signed [27:0] point_y;
    logic [DIST_W-1:0]  query_distance;
    logic               want_point;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [5:0]        string_index;
    logic [9:0]        pt_index;
    logic [DIST_W-1:0] string_start;
    logic [DIST_W-1:0] total_length;
    logic [6:0]        string_count;
  } out_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/cdim_seglen.sv =====
// ----------------------------------------------------------------------------
// cdim_seglen
// Segment length floor(sqrt(dx^2 + dy^2)): one shared multiplier for the two
// squares, then a radix-2 digit-by-digit square root, one digit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdim_seglen (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [27:0] dx,
  input  wire logic [27:0] dy,
  output logic             done,
  output logic [28:0]      root
);

  localparam logic [2:0] SG_IDLE = 3'd0;
  localparam logic [2:0] SG_MX   = 3'd1;
  localparam logic [2:0] SG_MY   = 3'd2;
  localparam logic [2:0] SG_ADD  = 3'd3;
  localparam logic [2:0] SG_ROOT = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [27:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [55:0] prod_r, prod_nxt;
  logic [57:0] rad_r, rad_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [28:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;

  logic [27:0] mul_op;
  logic [55:0] mul_p;
  logic [31:0] rem_sh, trial, diff;

  assign mul_op = (st_r == SG_MX) ? dx_r : dy_r;
  assign mul_p  = {28'b0, mul_op} * {28'b0, mul_op};
  assign rem_sh = {rem_r[29:0], rad_r[57:56]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    st_nxt   = st_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    prod_nxt = prod_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    unique case (st_r)
      SG_IDLE: begin
        if (start) begin
          dx_nxt = dx;
          dy_nxt = dy;
          st_nxt = SG_MX;
        end
      end
      SG_MX: begin
        prod_nxt = mul_p;
        st_nxt   = SG_MY;
      end
      SG_MY: begin
        rad_nxt  = {2'b00, prod_r};
        prod_nxt = mul_p;
        st_nxt   = SG_ADD;
      end
      SG_ADD: begin
        rad_nxt  = rad_r + {2'b00, prod_r};
        rem_nxt  = '0;
        root_nxt = '0;
        cnt_nxt  = '0;
        st_nxt   = SG_ROOT;
      end
      SG_ROOT: begin
        if (rem_sh >= trial) begin
          rem_nxt  = diff;
          root_nxt = {root_r[27:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[27:0], 1'b0};
        end
        rad_nxt = {rad_r[55:0], 2'b00};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd28) begin
          done_nxt = 1'b1;
          st_nxt   = SG_IDLE;
        end
      end
      default: st_nxt = SG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SG_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    prod_r <= prod_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ===== design/cumulative_distance_index_map_core.sv =====
// ----------------------------------------------------------------------------
// cumulative_distance_index_map_core
// Polyline map builder with distance and id lookup.
// ----------------------------------------------------------------------------
// One word at a time. Begin, add and end words scan the id store once, one
// entry a cycle; an add word then waits for the segment length unit (two
// squares on one multiplier and a 29-digit square root). An id lookup also
// scans the id store. A distance lookup runs two binary searches, the second
// only when a point is wanted, over the registered read ports of the polyline
// and point tables, each probe issuing a read in S_SS or S_PS and comparing
// its registered result in S_SSW or S_PSW. Once a result is loaded into the
// output register the input is ready again on the next cycle; a result
// finished while the previous one is still untaken waits, and no further
// word is taken until it has moved to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cumulative_distance_index_map_core #(
  parameter int MAX_STRINGS = 64,
  parameter int MAX_POINTS  = 1024,
  parameter int MAX_IDS     = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cdim_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cdim_pkg::out_t       out_data
);

  import cdim_pkg::*;

  localparam int SW  = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam int SCW = $clog2(MAX_STRINGS + 1);
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int IW  = $clog2(MAX_IDS);
  localparam int ICW = $clog2(MAX_IDS + 1);
  localparam int LW  = (SCW > PCW) ? SCW : PCW;
  localparam int TW  = SW + PW;
  localparam int RW  = PW + PCW + DIST_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_EXEC = 4'd3;
  localparam logic [3:0] S_SEG  = 4'd4;
  localparam logic [3:0] S_SS   = 4'd5;
  localparam logic [3:0] S_SSW  = 4'd6;
  localparam logic [3:0] S_SR   = 4'd7;
  localparam logic [3:0] S_SRW  = 4'd8;
  localparam logic [3:0] S_PS   = 4'd9;
  localparam logic [3:0] S_PSW  = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  // control
  logic [3:0]        state_r, state_nxt;
  in_t               req_r, req_nxt;
  out_t              res_r, res_nxt;
  out_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // map state
  logic [SCW-1:0]    committed_r, committed_nxt;
  logic [PCW-1:0]    used_r, used_nxt;
  logic [ICW-1:0]    id_count_r, id_count_nxt;
  logic [DIST_W-1:0] map_total_r, map_total_nxt;
  logic              building_r, building_nxt;
  logic [63:0]       cur_sid_r, cur_sid_nxt;
  logic [27:0]       prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [DIST_W-1:0] running_r, running_nxt;
  logic [PW-1:0]     cur_first_r, cur_first_nxt;
  logic [DIST_W-1:0] cur_start_r, cur_start_nxt;

  // id scan
  logic [ICW-1:0]    scan_i_r, scan_i_nxt;
  logic              chk_r, chk_nxt;
  logic [IW-1:0]     chk_idx_r, chk_idx_nxt;
  logic              found_a_r, found_a_nxt, found_b_r, found_b_nxt;
  logic [IW-1:0]     idx_b_r, idx_b_nxt;
  logic [TW-1:0]     tgt_b_r, tgt_b_nxt;

  // search
  logic [LW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [SW-1:0]     sel_s_r, sel_s_nxt;
  logic [PW-1:0]     sel_first_r, sel_first_nxt;
  logic [DIST_W-1:0] rel_r, rel_nxt;

  // memories
  logic [63:0]       id_key_m [MAX_IDS];
  logic [TW-1:0]     id_tgt_m [MAX_IDS];
  logic [DIST_W-1:0] pt_m     [MAX_POINTS];
  logic [RW-1:0]     row_m    [MAX_STRINGS];
  logic [63:0]       key_rd_r;
  logic [TW-1:0]     tgt_rd_r;
  logic [DIST_W-1:0] pt_rd_r;
  logic [RW-1:0]     row_rd_r;

  logic              id_we, pt_we, row_we;
  logic [IW-1:0]     id_wa;
  logic [63:0]       id_wkey;
  logic [TW-1:0]     id_wtgt;
  logic [DIST_W-1:0] pt_wd;
  logic [RW-1:0]     row_wd;
  logic [SW-1:0]     row_ra;
  logic [PW-1:0]     pt_ra;

  // helpers
  logic [LW:0]       lohi_sum;
  logic [LW-1:0]     mid_c, lo_m1;
  logic [ICW-1:0]    free_ids;
  logic [1:0]        need_b, need_e;
  logic [PCW-1:0]    pts_open;
  logic [28:0]       dxd, dyd, dxn, dyn;
  logic [27:0]       dx_abs, dy_abs;
  logic              seg_start, seg_done;
  logic [28:0]       seg_len;
  logic [DIST_W-1:0] run_add;
  logic [PW-1:0]     row_first;
  logic [PCW-1:0]    row_n;
  logic [DIST_W-1:0] row_start;
  logic [SW-1:0]     cs_idx;
  logic              do_put;
  logic [63:0]       put_key;
  logic [PW-1:0]     put_p;

  assign lohi_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c     = lohi_sum[LW:1];
  assign lo_m1     = lo_r - LW'(1);
  assign free_ids  = ICW'(MAX_IDS) - id_count_r;
  assign pts_open  = used_r - PCW'(cur_first_r);
  assign cs_idx    = committed_r[SW-1:0];
  assign row_first = row_rd_r[RW-1 -: PW];
  assign row_n     = row_rd_r[DIST_W +: PCW];
  assign row_start = row_rd_r[DIST_W-1:0];

  // room in the id store, keeping one slot for the polyline id where needed
  assign need_b = {1'b0, ~found_b_r} + {1'b0, (req_r.item_id != req_r.string_id)};
  assign need_e = {1'b0, ~found_b_r} + {1'b0, (req_r.item_id != cur_sid_r)};

  assign dxd    = {req_r.point_x[27], req_r.point_x} - {prev_x_r[27], prev_x_r};
  assign dyd    = {req_r.point_y[27], req_r.point_y} - {prev_y_r[27], prev_y_r};
  assign dxn    = 29'd0 - dxd;
  assign dyn    = 29'd0 - dyd;
  assign dx_abs = dxd[28] ? dxn[27:0] : dxd[27:0];
  assign dy_abs = dyd[28] ? dyn[27:0] : dyd[27:0];
  assign run_add = sat_add(running_r, DIST_W'(seg_len));

  assign row_ra = (state_r == S_SS) ? mid_c[SW-1:0] : sel_s_r;
  assign pt_ra  = sel_first_r + mid_c[PW-1:0];

  cdim_seglen u_seglen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seg_start),
    .dx    (dx_abs),
    .dy    (dy_abs),
    .done  (seg_done),
    .root  (seg_len)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    committed_nxt = committed_r;
    used_nxt      = used_r;
    id_count_nxt  = id_count_r;
    map_total_nxt = map_total_r;
    building_nxt  = building_r;
    cur_sid_nxt   = cur_sid_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    running_nxt   = running_r;
    cur_first_nxt = cur_first_r;
    cur_start_nxt = cur_start_r;
    scan_i_nxt    = scan_i_r;
    chk_nxt       = chk_r;
    chk_idx_nxt   = chk_idx_r;
    found_a_nxt   = found_a_r;
    found_b_nxt   = found_b_r;
    idx_b_nxt     = idx_b_r;
    tgt_b_nxt     = tgt_b_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    sel_s_nxt     = sel_s_r;
    sel_first_nxt = sel_first_r;
    rel_nxt       = rel_r;
    seg_start     = 1'b0;
    pt_we         = 1'b0;
    pt_wd         = '0;
    row_we        = 1'b0;
    row_wd        = {cur_first_r, pts_open, cur_start_r};
    do_put        = 1'b0;
    put_key       = req_r.item_id;
    put_p         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        res_nxt     = '0;
        scan_i_nxt  = '0;
        chk_nxt     = 1'b0;
        found_a_nxt = 1'b0;
        found_b_nxt = 1'b0;
        state_nxt   = S_SCAN;
        case (req_r.func) inside
          FN_BEGIN: begin
            // abandon an open polyline
            if (building_r) begin
              used_nxt     = PCW'(cur_first_r);
              building_nxt = 1'b0;
            end
          end
          FN_ADD, FN_END: begin
            if (!building_r) begin
              res_nxt.status = ST_EMPTY;
              state_nxt      = S_EMIT;
            end
          end
          FN_LKD: begin
            if (req_r.query_distance > map_total_r) begin
              res_nxt.status = ST_BEYOND;
              state_nxt      = S_EMIT;
            end else if (committed_r == '0) begin
              res_nxt.status = ST_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = LW'(committed_r);
              state_nxt = S_SS;
            end
          end
          FN_LKID: ;
          default: state_nxt = S_EMIT;
        endcase
      end

      S_SCAN: begin
        if (chk_r) begin
          if (key_rd_r == req_r.string_id) found_a_nxt = 1'b1;
          if (key_rd_r == ((req_r.func == FN_END) ? cur_sid_r : req_r.item_id)) begin
            found_b_nxt = 1'b1;
            idx_b_nxt   = chk_idx_r;
            tgt_b_nxt   = tgt_rd_r;
          end
        end
        if (scan_i_r < id_count_r) begin
          chk_nxt     = 1'b1;
          chk_idx_nxt = scan_i_r[IW-1:0];
          scan_i_nxt  = scan_i_r + ICW'(1);
        end else begin
          chk_nxt = 1'b0;
          if (!chk_r) state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_EMIT;
        case (req_r.func)
          FN_BEGIN: begin
            if (found_a_r) begin
              res_nxt.status = ST_DUP;
            end else if (committed_r >= SCW'(MAX_STRINGS) || used_r >= PCW'(MAX_POINTS) ||
                         free_ids < ICW'(need_b)) begin
              res_nxt.status = ST_FULL;
            end else begin
              building_nxt  = 1'b1;
              cur_sid_nxt   = req_r.string_id;
              cur_first_nxt = used_r[PW-1:0];
              cur_start_nxt = map_total_r;
              pt_we         = 1'b1;
              pt_wd         = '0;
              used_nxt      = used_r + PCW'(1);
              running_nxt   = '0;
              prev_x_nxt    = req_r.point_x;
              prev_y_nxt    = req_r.point_y;
              do_put        = 1'b1;
              res_nxt.string_index = 6'(cs_idx);
              res_nxt.string_start = map_total_r;
            end
          end
          FN_ADD: begin
            if (used_r >= PCW'(MAX_POINTS) || free_ids < ICW'(need_e)) begin
              res_nxt.status = ST_FULL;
            end else begin
              seg_start = 1'b1;
              state_nxt = S_SEG;
            end
          end
          FN_END: begin
            row_we        = 1'b1;
            put_key       = cur_sid_r;
            do_put        = 1'b1;
            map_total_nxt = sat_add(cur_start_r, running_r);
            committed_nxt = committed_r + SCW'(1);
            building_nxt  = 1'b0;
            res_nxt.string_index = 6'(cs_idx);
            res_nxt.pt_index     = 10'(pts_open - PCW'(1));
            res_nxt.string_start = cur_start_r;
          end
          FN_LKID: begin
            if (!found_b_r) begin
              res_nxt.status = ST_NOTFOUND;
            end else begin
              sel_s_nxt = tgt_b_r[TW-1 -: SW];
              res_nxt.string_index = 6'(tgt_b_r[TW-1 -: SW]);
              res_nxt.pt_index     = 10'(tgt_b_r[PW-1:0]);
              if (SCW'(tgt_b_r[TW-1 -: SW]) < committed_r) begin
                state_nxt = S_SR;
              end else begin
                res_nxt.string_start = map_total_r;
              end
            end
          end
          default: ;
        endcase
      end

      S_SEG: begin
        if (seg_done) begin
          running_nxt = run_add;
          pt_we       = 1'b1;
          pt_wd       = run_add;
          used_nxt    = used_r + PCW'(1);
          prev_x_nxt  = req_r.point_x;
          prev_y_nxt  = req_r.point_y;
          do_put      = 1'b1;
          put_p       = pts_open[PW-1:0];
          res_nxt.string_index = 6'(cs_idx);
          res_nxt.pt_index     = 10'(pts_open);
          res_nxt.string_start = cur_start_r;
          state_nxt   = S_EMIT;
        end
      end

      S_SS: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = S_SSW;
        end else begin
          sel_s_nxt = (lo_r != '0) ? lo_m1[SW-1:0] : '0;
          state_nxt = S_SR;
        end
      end

      S_SSW: begin
        if (row_start < req_r.query_distance) lo_nxt = mid_r + LW'(1);
        else hi_nxt = mid_r;
        state_nxt = S_SS;
      end

      S_SR: state_nxt = S_SRW;

      S_SRW: begin
        state_nxt = S_EMIT;
        if (req_r.func == FN_LKID) begin
          res_nxt.string_start = row_start;
        end else begin
          sel_first_nxt = row_first;
          res_nxt.string_index = 6'(sel_s_r);
          res_nxt.string_start = row_start;
          if (req_r.want_point) begin
            rel_nxt   = req_r.query_distance - row_start;
            lo_nxt    = '0;
            hi_nxt    = LW'(row_n);
            state_nxt = S_PS;
          end
        end
      end

      S_PS: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = S_PSW;
        end else begin
          res_nxt.pt_index = (lo_r != '0) ? 10'(lo_m1) : 10'd0;
          state_nxt = S_EMIT;
        end
      end

      S_PSW: begin
        if (pt_rd_r < rel_r) lo_nxt = mid_r + LW'(1);
        else hi_nxt = mid_r;
        state_nxt = S_PS;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt              = res_r;
          out_nxt.total_length = map_total_r;
          out_nxt.string_count = 7'(committed_r);
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // id store write: existing key in place, new key at the fill mark
    id_we   = do_put && (found_b_r || id_count_r < ICW'(MAX_IDS));
    id_wa   = found_b_r ? idx_b_r : id_count_r[IW-1:0];
    id_wkey = put_key;
    id_wtgt = {cs_idx, put_p};
    if (do_put && !found_b_r && id_count_r < ICW'(MAX_IDS))
      id_count_nxt = id_count_r + ICW'(1);
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_key_m[id_wa] <= id_wkey;
      id_tgt_m[id_wa] <= id_wtgt;
    end
    key_rd_r <= id_key_m[scan_i_r[IW-1:0]];
    tgt_rd_r <= id_tgt_m[scan_i_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_m[used_r[PW-1:0]] <= pt_wd;
    pt_rd_r <= pt_m[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_m[cs_idx] <= row_wd;
    row_rd_r <= row_m[row_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      committed_r <= '0;
      used_r      <= '0;
      id_count_r  <= '0;
      map_total_r <= '0;
      building_r  <= 1'b0;
      cur_sid_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      running_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      committed_r <= committed_nxt;
      used_r      <= used_nxt;
      id_count_r  <= id_count_nxt;
      map_total_r <= map_total_nxt;
      building_r  <= building_nxt;
      cur_sid_r   <= cur_sid_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      running_r   <= running_nxt;
    end
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
    cur_first_r <= cur_first_nxt;
    cur_start_r <= cur_start_nxt;
    scan_i_r    <= scan_i_nxt;
    chk_r       <= chk_nxt;
    chk_idx_r   <= chk_idx_nxt;
    found_a_r   <= found_a_nxt;
    found_b_r   <= found_b_nxt;
    idx_b_r     <= idx_b_nxt;
    tgt_b_r     <= tgt_b_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    sel_s_r     <= sel_s_nxt;
    sel_first_r <= sel_first_nxt;
    rel_r       <= rel_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_open_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    building_r |-> committed_r < SCW'(MAX_STRINGS))
    else $error("open polyline with no free table row");

  a_points_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= PCW'(MAX_POINTS) && id_count_r <= ICW'(MAX_IDS))
    else $error("point or id fill beyond capacity");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");
`endif

endmodule

`default_nettype wire
